// ----- rtl/core/apc_pkg.sv -----
// Shared types and constants of the aperture point clip block.
package apc_pkg;

   localparam int DEF_MAX_VERTICES = 16;
   localparam int DEF_COORD_WIDTH  = 24;

   localparam int MODE_W     = 3;
   localparam int RADIUS_W   = 23;
   localparam int COUNT_W    = 5;
   localparam int VIDX_W     = 4;
   localparam int CSR_DATA_W = 23;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE        = 3'd0,
      MODE_CIRCULAR    = 3'd1,
      MODE_OBSTRUCTION = 3'd2,
      MODE_ANNULUS     = 3'd3,
      MODE_POLYGON     = 3'd4
   } aperture_mode_type;

   typedef enum logic [1:0] {
      CSR_MODE       = 2'd0,
      CSR_RADIUS_MAX = 2'd1,
      CSR_RADIUS_MIN = 2'd2,
      CSR_VTX_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_VERTEX_WRITE = 1'b0,
      FUNC_POINT_TEST   = 1'b1
   } func_type;

   // Load strobes for the edge cell's pipeline registers.
   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
   } edge_ctl_type;

endpackage

// ----- rtl/core/apc_edge.sv -----
// One polygon edge cell: exact crossing and left-of-edge test, three stages.
module apc_edge #(
   parameter int COORD_WIDTH = apc_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  apc_pkg::edge_ctl_type         ctl,
   input  logic                          active,
   input  logic signed [COORD_WIDTH-1:0] pt_x,
   input  logic signed [COORD_WIDTH-1:0] pt_y,
   input  logic signed [COORD_WIDTH-1:0] vi_x,
   input  logic signed [COORD_WIDTH-1:0] vi_y,
   input  logic signed [COORD_WIDTH-1:0] vj_x,
   input  logic signed [COORD_WIDTH-1:0] vj_y,
   output logic                          toggle
);
   import apc_pkg::*;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;

   logic signed [DIFF_W-1:0] a_in, b_in, c_in, d_in;
   logic signed [DIFF_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic                     cross_in, cross_ff, cross2_ff;
   logic signed [PROD_W-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic                     bpos_ff;
   logic                     left;
   logic                     toggle_in, toggle_ff;

   // Stage 2: differences against the edge's start vertex.
   assign a_in     = pt_x - vi_x;
   assign b_in     = vj_y - vi_y;
   assign c_in     = vj_x - vi_x;
   assign d_in     = pt_y - vi_y;
   assign cross_in = active && ((vi_y > pt_y) != (vj_y > pt_y));

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         cross_ff <= cross_in;
      end
   end

   // Stage 3: both cross products.
   assign p1_in = a_ff * b_ff;
   assign p2_in = c_ff * d_ff;

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         bpos_ff   <= (b_ff > 0);
         cross2_ff <= cross_ff;
      end
   end

   // Stage 4: point strictly left of the edge; flip the compare for a falling edge.
   assign left      = bpos_ff ? (p1_ff < p2_ff) : (p2_ff < p1_ff);
   assign toggle_in = cross2_ff && left;

   always_ff @(posedge clock) begin
      if (ctl.load4) begin
         toggle_ff <= toggle_in;
      end
   end

   assign toggle = toggle_ff;

endmodule

// ----- rtl/core/aperture_point_clip.sv -----
// Top level of the aperture point clip block: vertex store, radial and polygon pipelines.
//
// Each beat on req_ carries either a polygon vertex write (req_tuser low) or a point
// test (req_tuser high). A vertex write lands in the vertex store at the cycle it is
// accepted and returns nothing; a write to an index at or above MAX_VERTICES is
// dropped. A point test returns exactly one beat on rsp_ whose bit 0 is high when the
// aperture blocks the point: outside radius_max (circular), inside radius_min
// (obstruction), either (annulus), or outside the stored polygon by even-odd crossing
// parity (polygon, using vertices 0 to vertex_count-1, vertex_count saturated at
// MAX_VERTICES; a count of zero never clips). Unknown mode codes never clip. A point
// sees every vertex write accepted before it. The block takes one beat per cycle while
// rsp_tready does not hold the pipeline back; a point test passes five register stages
// (input capture, differences and squares, products and distance sum, compares, parity
// and mode select), and its result waits in the last one until rsp_tready takes it.
// One edge cell per vertex carries two 25x25-bit multipliers. Result order equals
// request order. Write the csr_ registers only while no point is in flight, and read a
// polygon vertex only after writing it.
module aperture_point_clip #(
   parameter int MAX_VERTICES = apc_pkg::DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = apc_pkg::DEF_COORD_WIDTH,
   localparam int REQ_DATA_W  = ((apc_pkg::VIDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, low bit up: vertex_index[3:0], coord_x, coord_y, zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_W-1:0]               req_tdata,
   // req_tuser: func (0 vertex write, 1 point test)
   input  logic [0:0]                          req_tuser,
   // rsp_tdata, low bit up: clipped, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [apc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  apc_pkg::csr_index_type              csr_index,
   input  logic [apc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import apc_pkg::*;

   localparam int IW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW      = $clog2(MAX_VERTICES + 1);
   localparam int SQ_W    = 2 * COORD_WIDTH;
   localparam int DIST_W  = SQ_W + 1;
   localparam int R2_W    = 2 * RADIUS_W;
   localparam int CMP_W   = (DIST_W > R2_W) ? DIST_W : R2_W;

   // Configuration registers.
   logic [MODE_W-1:0]   mode_ff;
   logic [RADIUS_W-1:0] rmax_ff;
   logic [RADIUS_W-1:0] rmin_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         rmax_ff  <= '0;
         rmin_ff  <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:       mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_RADIUS_MAX: rmax_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_RADIUS_MIN: rmin_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_VTX_COUNT:  count_ff <= csr_wdata[COUNT_W-1:0];
            default:        ;
         endcase
      end
   end

   // Unpack the request beat.
   logic [VIDX_W-1:0]             in_index;
   logic signed [COORD_WIDTH-1:0] in_x, in_y;
   logic                          req_fire;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;

   assign in_index = req_tdata[VIDX_W-1:0];
   assign in_x     = req_tdata[VIDX_W +: COORD_WIDTH];
   assign in_y     = req_tdata[VIDX_W + COORD_WIDTH +: COORD_WIDTH];
   assign req_fire = req_tvalid && req_tready;
   assign wr_en    = req_fire && (req_tuser[0] == FUNC_VERTEX_WRITE)
                     && (int'(in_index) < MAX_VERTICES);
   assign wr_addr  = IW'(in_index);

   // Pipeline handshake: a stage loads when it is empty or its successor moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic ready1, ready2, ready3, ready4, ready5;

   assign ready5     = !v5_ff || rsp_tready;
   assign ready4     = !v4_ff || ready5;
   assign ready3     = !v3_ff || ready4;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   // Hold off vertex writes too while stage 1 stalls, so a held point reads a stable store.
   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_fire && (req_tuser[0] == FUNC_POINT_TEST);
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
         if (ready5) v5_ff <= v4_ff;
      end
   end

   // Vertex store: each edge cell reads its own two entries, the closing edge a mux.
   logic signed [COORD_WIDTH-1:0] poly_x_ff [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] poly_y_ff [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         poly_x_ff[wr_addr] <= in_x;
         poly_y_ff[wr_addr] <= in_y;
      end
   end

   // Stage 1: captured point.
   logic signed [COORD_WIDTH-1:0] pt_x_ff, pt_y_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         pt_x_ff <= in_x;
         pt_y_ff <= in_y;
      end
   end

   // Vertices in use, saturated, and the last one that closes the polygon.
   logic [NW-1:0] n_sat;
   logic [IW-1:0] last_idx;

   assign n_sat    = (int'(count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_ff);
   assign last_idx = IW'(n_sat - NW'(1));

   edge_ctl_type              edge_ctl;
   logic [MAX_VERTICES-1:0]   toggle;

   assign edge_ctl.load2 = ready2;
   assign edge_ctl.load3 = ready3;
   assign edge_ctl.load4 = ready4;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_edge
      logic signed [COORD_WIDTH-1:0] vj_x, vj_y;
      logic                          active;

      if (i == 0) begin : g_close
         assign vj_x = poly_x_ff[last_idx];
         assign vj_y = poly_y_ff[last_idx];
      end else begin : g_chain
         assign vj_x = poly_x_ff[i-1];
         assign vj_y = poly_y_ff[i-1];
      end

      assign active = (n_sat > NW'(i));

      apc_edge #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_edge (
         .clock  (clock),
         .ctl    (edge_ctl),
         .active (active),
         .pt_x   (pt_x_ff),
         .pt_y   (pt_y_ff),
         .vi_x   (poly_x_ff[i]),
         .vi_y   (poly_y_ff[i]),
         .vj_x   (vj_x),
         .vj_y   (vj_y),
         .toggle (toggle[i])
      );
   end

   // Stage 2: squares of the point and of both radii.
   logic signed [SQ_W-1:0] sq_x_in, sq_y_in;
   logic [SQ_W-1:0]        sq_x_ff, sq_y_ff;
   logic [R2_W-1:0]        r2max_in, r2min_in;
   logic [R2_W-1:0]        r2max_ff, r2min_ff;

   assign sq_x_in  = pt_x_ff * pt_x_ff;
   assign sq_y_in  = pt_y_ff * pt_y_ff;
   assign r2max_in = R2_W'(rmax_ff) * R2_W'(rmax_ff);
   assign r2min_in = R2_W'(rmin_ff) * R2_W'(rmin_ff);

   always_ff @(posedge clock) begin
      if (ready2) begin
         sq_x_ff  <= sq_x_in;
         sq_y_ff  <= sq_y_in;
         r2max_ff <= r2max_in;
         r2min_ff <= r2min_in;
      end
   end

   // Stage 3: squared distance.
   logic [DIST_W-1:0] dist2_ff;
   logic [R2_W-1:0]   r2max3_ff, r2min3_ff;

   always_ff @(posedge clock) begin
      if (ready3) begin
         dist2_ff  <= DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
         r2max3_ff <= r2max_ff;
         r2min3_ff <= r2min_ff;
      end
   end

   // Stage 4: radial compares.
   logic outer_ff, inner_ff;

   always_ff @(posedge clock) begin
      if (ready4) begin
         outer_ff <= CMP_W'(dist2_ff) > CMP_W'(r2max3_ff);
         inner_ff <= CMP_W'(dist2_ff) < CMP_W'(r2min3_ff);
      end
   end

   // Stage 5: crossing parity and mode select into the output register.
   logic parity;
   logic clip_in, clip_ff;

   assign parity = ^toggle;

   always_comb begin
      case (mode_ff)
         MODE_CIRCULAR:    clip_in = outer_ff;
         MODE_OBSTRUCTION: clip_in = inner_ff;
         MODE_ANNULUS:     clip_in = outer_ff || inner_ff;
         MODE_POLYGON:     clip_in = (count_ff != '0) && !parity;
         default:          clip_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready5) begin
         clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, clip_ff};

   // A vertex write never enters the point pipeline.
   a_write_no_point : assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser[0] == FUNC_VERTEX_WRITE) |=> !v1_ff)
      else $error("vertex write entered the point pipeline");

   // An empty input stage always takes a beat.
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("input stalled with stage 1 empty");

   // Mode none never clips.
   a_none_open : assert property (@(posedge clock) disable iff (reset)
      ready5 && (mode_ff == MODE_NONE) |=> !clip_ff)
      else $error("clip raised in mode none");

   // Circular mode clips only outside the outer radius.
   a_circ_outer : assert property (@(posedge clock) disable iff (reset)
      ready5 && (mode_ff == MODE_CIRCULAR) && !outer_ff |=> !clip_ff)
      else $error("circular clip without outer hit");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for aperture_point_clip: a directed table, then randomized phases.
`timescale 1ns / 100ps

module tb_top;
   import apc_pkg::*;

   localparam int COORD_W      = DEF_COORD_WIDTH;
   localparam int MAX_VTX      = DEF_MAX_VERTICES;
   localparam int REQ_W        = ((VIDX_W + 2 * COORD_W + 7) / 8) * 8;
   localparam int PIPE_LATENCY = 5;      // accept edge to result edge, no back-pressure
   localparam int RESET_CYCLES = 12;
   localparam int TOTAL_BEATS  = 1550;
   localparam int QUIET_LIMIT  = 1000;   // cycles with no beat on either side

   // Mode codes with no name in the package; the block treats them as none.
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam logic signed [COORD_W-1:0] Q_ONE     = 24'sd4096;   // 1.0 in Q11.12
   localparam logic [RADIUS_W-1:0]       RADIUS_TOP = '1;

   typedef enum logic [1:0] {
      STEP_CSR,
      STEP_VERTEX,
      STEP_POINT
   } step_kind_type;

   // One row of the directed table. known/clip carry a result read straight off the
   // spec; rows with known low go through the predictor.
   typedef struct {
      step_kind_type             kind;
      csr_index_type             sel;
      logic [CSR_DATA_W-1:0]     value;
      logic [VIDX_W-1:0]         vidx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      known;
      logic                      clip;
   } probe_step_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   csr_index_type          csr_index  = CSR_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Aperture shadow state, updated in acceptance order.
   logic [MODE_W-1:0]         ap_mode  = MODE_NONE;
   logic [RADIUS_W-1:0]       ap_rmax  = '0;
   logic [RADIUS_W-1:0]       ap_rmin  = '0;
   logic [COUNT_W-1:0]        ap_count = '0;
   logic signed [COORD_W-1:0] vtx_x [MAX_VTX];
   logic signed [COORD_W-1:0] vtx_y [MAX_VTX];

   logic clip_expected[$];   // clipped flags of accepted point tests, oldest first
   int   fault_count  = 0;
   int   beats_sent   = 0;
   int   quiet_cycles = 0;
   logic tx_calm      = 1'b0;   // sender runs back to back
   logic rx_calm      = 1'b0;   // receiver never stalls

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   aperture_point_clip DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   // Even-odd crossing test over the first vertex_count stored vertices. Products
   // stay below 2^49, so plain 64-bit cross-multiplication is exact.
   function automatic logic point_in_polygon(input longint x, input longint y);
      int     n, i, j;
      longint xi, yi, xj, yj, dy;
      logic   odd, left;
      n   = (ap_count > MAX_VTX) ? MAX_VTX : int'(ap_count);
      odd = 1'b0;
      j   = n - 1;
      for (i = 0; i < n; i++) begin
         xi = vtx_x[i];
         yi = vtx_y[i];
         xj = vtx_x[j];
         yj = vtx_y[j];
         if ((yi > y) != (yj > y)) begin
            dy = yj - yi;
            // keep the divisor positive so the inequality does not flip
            if (dy > 0)
               left = (x - xi) * dy < (xj - xi) * (y - yi);
            else
               left = (xj - xi) * (y - yi) < (x - xi) * dy;
            if (left)
               odd = !odd;
         end
         j = i;
      end
      return odd;
   endfunction

   function automatic logic predict_clip(input logic signed [COORD_W-1:0] px, py);
      longint x, y, dist2;
      logic   outer, inner, clip;
      x     = px;
      y     = py;
      dist2 = x * x + y * y;
      outer = dist2 > longint'(ap_rmax) * longint'(ap_rmax);
      inner = dist2 < longint'(ap_rmin) * longint'(ap_rmin);
      case (ap_mode)
         MODE_CIRCULAR:    clip = outer;
         MODE_OBSTRUCTION: clip = inner;
         MODE_ANNULUS:     clip = outer || inner;
         MODE_POLYGON:     clip = (ap_count != 0) && !point_in_polygon(x, y);
         default:          clip = 1'b0;
      endcase
      return clip;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Drive one register write; the caller drops csr_we after the last of a group.
   task automatic csr_write(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_MODE:       ap_mode  = value[MODE_W-1:0];
         CSR_RADIUS_MAX: ap_rmax  = value[RADIUS_W-1:0];
         CSR_RADIUS_MIN: ap_rmin  = value[RADIUS_W-1:0];
         CSR_VTX_COUNT:  ap_count = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Hold the sender until every point in flight has answered, then let the pipe drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (clip_expected.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2)
         @(posedge clock);
   endtask

   // Offer one request beat, wait for the handshake, then update the shadow state.
   task automatic send_beat(input func_type func, input logic [VIDX_W-1:0] vidx,
                            input logic signed [COORD_W-1:0] x, y,
                            input logic known, clip);
      logic [REQ_W-1:0] beat;
      int               gap;
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap)
            @(posedge clock);
      end
      beat                                 = '0;
      beat[VIDX_W-1:0]                     = vidx;
      beat[VIDX_W +: COORD_W]              = x;
      beat[VIDX_W + COORD_W +: COORD_W]    = y;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= func;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      beats_sent++;
      if (func == FUNC_VERTEX_WRITE) begin
         vtx_x[vidx] = x;
         vtx_y[vidx] = y;
      end else begin
         clip_expected.push_back(known ? clip : predict_clip(x, y));
      end
   endtask

   // ---------------------------------------------------------------- generators

   // Coordinate within +/- 2^scale, with the field extremes mixed in.
   function automatic logic signed [COORD_W-1:0] pick_coord(input int scale);
      int unsigned span;
      int          sel;
      span = 1 << scale;
      sel  = $urandom_range(0, 15);
      case (sel)
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         default: return $urandom_range(0, 2 * span - 1) - span;
      endcase
   endfunction

   function automatic logic [RADIUS_W-1:0] pick_radius(input int scale);
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return '0;
         1:       return RADIUS_TOP;
         default: return $urandom_range(0, (1 << scale) - 1);
      endcase
   endfunction

   function automatic probe_step_type csr_row(input csr_index_type sel,
                                              input logic [CSR_DATA_W-1:0] value);
      probe_step_type row;
      row       = '{STEP_CSR, sel, value, '0, '0, '0, 1'b0, 1'b0};
      return row;
   endfunction

   function automatic probe_step_type vtx_row(input logic [VIDX_W-1:0] vidx,
                                              input logic signed [COORD_W-1:0] x, y);
      probe_step_type row;
      row       = '{STEP_VERTEX, CSR_MODE, '0, vidx, x, y, 1'b0, 1'b0};
      return row;
   endfunction

   function automatic probe_step_type pt_row(input logic signed [COORD_W-1:0] x, y,
                                             input logic known, clip);
      probe_step_type row;
      row       = '{STEP_POINT, CSR_MODE, '0, '0, x, y, known, clip};
      return row;
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      probe_step_type            plan[$];
      int                        phase_len, scale, n, sel, k, k2;
      logic [MODE_W-1:0]         mode;
      logic [COUNT_W-1:0]        count;
      logic signed [COORD_W-1:0] px, py;

      // After reset the mode is none: nothing clips, even at the corners.
      plan.push_back(pt_row('0, '0, 1'b1, 1'b0));
      plan.push_back(pt_row(COORD_MAX, COORD_MAX, 1'b1, 1'b0));
      plan.push_back(pt_row(COORD_MIN, COORD_MIN, 1'b1, 1'b0));
      // Circular at the widest radius: the far corner clips, the rim itself does not.
      plan.push_back(csr_row(CSR_MODE, MODE_CIRCULAR));
      plan.push_back(csr_row(CSR_RADIUS_MAX, RADIUS_TOP));
      plan.push_back(pt_row(COORD_MIN, COORD_MIN, 1'b1, 1'b1));
      plan.push_back(pt_row(RADIUS_TOP, '0, 1'b1, 1'b0));
      // Zero radius: only the origin survives.
      plan.push_back(csr_row(CSR_RADIUS_MAX, '0));
      plan.push_back(pt_row('0, '0, 1'b1, 1'b0));
      plan.push_back(pt_row(24'sd1, '0, 1'b1, 1'b1));
      // Obstruction at the widest radius: the rim is not inside, the origin is.
      plan.push_back(csr_row(CSR_MODE, MODE_OBSTRUCTION));
      plan.push_back(csr_row(CSR_RADIUS_MIN, RADIUS_TOP));
      plan.push_back(pt_row(RADIUS_TOP, '0, 1'b1, 1'b0));
      plan.push_back(pt_row('0, '0, 1'b1, 1'b1));
      // Annulus from 0.5 to 1.0: both rims and just past each.
      plan.push_back(csr_row(CSR_MODE, MODE_ANNULUS));
      plan.push_back(csr_row(CSR_RADIUS_MAX, Q_ONE));
      plan.push_back(csr_row(CSR_RADIUS_MIN, Q_ONE / 2));
      plan.push_back(pt_row(Q_ONE, '0, 1'b0, 1'b0));
      plan.push_back(pt_row(Q_ONE + 1, '0, 1'b0, 1'b0));
      plan.push_back(pt_row('0, -(Q_ONE / 2), 1'b0, 1'b0));
      plan.push_back(pt_row('0, -(Q_ONE / 2) + 1, 1'b0, 1'b0));
      // Spare mode code: never clips.
      plan.push_back(csr_row(CSR_MODE, MODE_SPARE_HI));
      plan.push_back(pt_row(COORD_MIN, COORD_MAX, 1'b1, 1'b0));
      // Square from -1.0 to 1.0, then an empty polygon, then the square in use.
      plan.push_back(vtx_row(4'd0, -Q_ONE, -Q_ONE));
      plan.push_back(vtx_row(4'd1, Q_ONE, -Q_ONE));
      plan.push_back(vtx_row(4'd2, Q_ONE, Q_ONE));
      plan.push_back(vtx_row(4'd3, -Q_ONE, Q_ONE));
      plan.push_back(csr_row(CSR_MODE, MODE_POLYGON));
      plan.push_back(csr_row(CSR_VTX_COUNT, '0));
      plan.push_back(pt_row(COORD_MAX, COORD_MAX, 1'b1, 1'b0));
      plan.push_back(csr_row(CSR_VTX_COUNT, 4));
      plan.push_back(pt_row('0, '0, 1'b0, 1'b0));
      plan.push_back(pt_row(2 * Q_ONE, '0, 1'b0, 1'b0));
      plan.push_back(pt_row(Q_ONE, '0, 1'b0, 1'b0));
      plan.push_back(pt_row(-Q_ONE, Q_ONE, 1'b0, 1'b0));
      plan.push_back(pt_row('0, Q_ONE, 1'b0, 1'b0));

      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;

      // Walk the table; a run of register rows is one idle window.
      foreach (plan[s]) begin
         case (plan[s].kind)
            STEP_CSR: begin
               if (s == 0 || plan[s-1].kind != STEP_CSR)
                  settle();
               csr_write(plan[s].sel, plan[s].value);
               if (s == plan.size() - 1 || plan[s+1].kind != STEP_CSR)
                  csr_we <= 1'b0;
            end
            STEP_VERTEX:
               send_beat(FUNC_VERTEX_WRITE, plan[s].vidx, plan[s].x, plan[s].y, 1'b0, 1'b0);
            default:
               send_beat(FUNC_POINT_TEST, plan[s].vidx, plan[s].x, plan[s].y,
                         plan[s].known, plan[s].clip);
         endcase
      end

      // Random phases: drain, reprogram, build a polygon if needed, then test points.
      while (beats_sent < TOTAL_BEATS) begin
         settle();
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         scale   = $urandom_range(6, COORD_W - 1);

         sel = $urandom_range(0, 19);
         if (sel < 8)
            mode = MODE_POLYGON;
         else if (sel < 11)
            mode = MODE_CIRCULAR;
         else if (sel < 14)
            mode = MODE_OBSTRUCTION;
         else if (sel < 17)
            mode = MODE_ANNULUS;
         else if (sel < 18)
            mode = MODE_NONE;
         else
            mode = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);

         // Mostly small polygons; now and then empty, degenerate, full or saturating.
         sel = $urandom_range(0, 15);
         if (sel == 0)
            count = '0;
         else if (sel == 1)
            count = $urandom_range(1, 2);
         else if (sel == 2)
            count = $urandom_range(MAX_VTX + 1, (1 << COUNT_W) - 1);
         else if (sel == 3)
            count = MAX_VTX;
         else
            count = $urandom_range(3, 12);

         csr_write(CSR_MODE, mode);
         csr_write(CSR_RADIUS_MAX, pick_radius(scale));
         csr_write(CSR_RADIUS_MIN, pick_radius(scale));
         csr_write(CSR_VTX_COUNT, count);
         csr_we <= 1'b0;

         // Fill every entry the polygon will read before any point touches it.
         n = 0;
         if (mode == MODE_POLYGON) begin
            n = (count > MAX_VTX) ? MAX_VTX : int'(count);
            for (k = 0; k < n; k++) begin
               px = pick_coord(scale);
               // share a y with the previous vertex now and then: horizontal edges
               py = (k > 0 && $urandom_range(0, 3) == 0) ? vtx_y[k-1] : pick_coord(scale);
               send_beat(FUNC_VERTEX_WRITE, k, px, py, 1'b0, 1'b0);
            end
         end

         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            if ($urandom_range(0, 15) == 0) begin
               // rewrite a vertex mid-stream; later points must see it
               send_beat(FUNC_VERTEX_WRITE, $urandom_range(0, MAX_VTX - 1),
                         pick_coord(scale), pick_coord(scale), 1'b0, 1'b0);
            end else begin
               px  = pick_coord(scale);
               py  = pick_coord(scale);
               sel = $urandom_range(0, 9);
               if (n > 0) begin
                  k  = $urandom_range(0, n - 1);
                  k2 = (k + 1) % n;
                  case (sel)
                     0: begin
                        px = vtx_x[k];
                        py = vtx_y[k];
                     end
                     1: py = vtx_y[k];
                     2: begin
                        px = (int'(vtx_x[k]) + int'(vtx_x[k2])) >>> 1;
                        py = (int'(vtx_y[k]) + int'(vtx_y[k2])) >>> 1;
                     end
                     default: ;
                  endcase
               end else if (sel == 0) begin
                  px = $signed({1'b0, ap_rmax});
                  py = '0;
               end else if (sel == 1) begin
                  px = '0;
                  py = -$signed({1'b0, ap_rmin});
               end
               send_beat(FUNC_POINT_TEST, $urandom_range(0, MAX_VTX - 1), px, py,
                         1'b0, 1'b0);
            end
         end
      end

      // Drain, then give stray results a chance to show up.
      req_tvalid <= 1'b0;
      while (clip_expected.size() != 0)
         @(posedge clock);
      repeat (4 * PIPE_LATENCY)
         @(posedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // Stall for a random number of cycles after each result beat; none in calm phases.
   initial begin : drain_rsp
      int stall;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall)
                  @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Compare each result beat against the oldest outstanding point test.
   always @(posedge clock) begin : check_rsp
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (clip_expected.size() == 0) begin
            $display("%0t: result with no point pending, expected none, actual clipped=%0b",
                     $time, rsp_tdata[0]);
            fault_count++;
         end else begin
            want = clip_expected.pop_front();
            if (rsp_tdata[0] !== want) begin
               $display("%0t: clipped mismatch, expected %0b, actual %0b",
                        $time, want, rsp_tdata[0]);
               fault_count++;
            end
         end
      end
   end

   // Drop the run if neither side moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

// ----- sim.f -----
rtl/core/apc_pkg.sv
rtl/core/apc_edge.sv
rtl/core/aperture_point_clip.sv
tb/tb_top.sv
